// ===== rtl/core/argb_box_blur_filter_assert.svh =====
// Assertion macros used by the block's port-level checker
`ifndef ARGB_BOX_BLUR_FILTER_ASSERT_SVH
`define ARGB_BOX_BLUR_FILTER_ASSERT_SVH

// same-cycle implication
`define BBF_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("box blur check failed");

// next-cycle implication
`define BBF_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("box blur check failed");

`endif

// ===== rtl/core/bbf_pkg.sv =====
// Types, constants and helper functions of the box blur filter
`default_nettype none
package bbf_pkg;

  localparam int MAX_KERNEL = 15;
  localparam int MAX_WIDTH  = 2048;

  localparam int COL_W      = $clog2(MAX_WIDTH);        // column index bits
  localparam int ROW_W      = 12;                       // row counter bits
  localparam int SLOT_W     = $clog2(MAX_KERNEL);       // line store row bits
  localparam int LS_ADDR_W  = SLOT_W + COL_W;
  localparam int LS_DEPTH   = MAX_KERNEL * MAX_WIDTH;
  localparam int CS_W       = 12;                       // one channel column sum
  localparam int WS_W       = 16;                       // one channel window sum
  localparam int RECIP_W    = 25;
  localparam int RECIP_SH   = 24;
  localparam int FS_W       = 24;                       // frame step counter
  localparam int DLY_W      = 15;
  localparam int PADDR_W    = 4;

  localparam logic [11:0]       MAX_W_VAL   = 12'(MAX_WIDTH);
  localparam logic [SLOT_W-1:0] LAST_SLOT   = SLOT_W'(MAX_KERNEL - 1);
  localparam logic [7:0]        ALPHA_FULL  = 8'hFF;

  localparam logic [1:0] REG_KERNEL_SIZE  = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic [3:0]  KERNEL_RST = 4'd3;
  localparam logic [11:0] WIDTH_RST  = 12'd640;
  localparam logic [11:0] HEIGHT_RST = 12'd480;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DIVIDE
  } bbf_state_t;

  typedef struct packed {
    logic [3:0]  kernel_size;
    logic [11:0] image_width;
    logic [11:0] image_height;
  } bbf_cfg_t;

  typedef logic [2:0][CS_W-1:0] bbf_col_t;

  // ceil(2^24 / (k*k)) for odd k; exact truncating quotient for window sums
  function automatic logic [RECIP_W-1:0] bbf_recip(input logic [3:0] k);
    logic [RECIP_W-1:0] r;
    case (k)
      4'd3:    r = 25'd1864136;
      4'd5:    r = 25'd671089;
      4'd7:    r = 25'd342393;
      4'd9:    r = 25'd207127;
      4'd11:   r = 25'd138655;
      4'd13:   r = 25'd99274;
      4'd15:   r = 25'd74566;
      default: r = 25'd16777216;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/bbf_stream_if.sv =====
// Pixel input and output stream interfaces
`default_nettype none
interface bbf_pix_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_in;
  logic        drain;
  modport source (output valid, output pixel_in, output drain, input ready);
  modport sink   (input valid, input pixel_in, input drain, output ready);
endinterface

interface bbf_pix_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_out;
  logic        end_of_frame;
  modport source (output valid, output pixel_out, output end_of_frame, input ready);
  modport sink   (input valid, input pixel_out, input end_of_frame, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/bbf_cfg.sv =====
// APB configuration registers of the box blur filter
`default_nettype none
module bbf_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bbf_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output bbf_pkg::bbf_cfg_t             cfg
);
  import bbf_pkg::*;

  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kernel_size  <= KERNEL_RST;
      cfg.image_width  <= WIDTH_RST;
      cfg.image_height <= HEIGHT_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_KERNEL_SIZE:  cfg.kernel_size  <= pwdata[3:0];
        REG_IMAGE_WIDTH:  cfg.image_width  <= pwdata[11:0];
        REG_IMAGE_HEIGHT: cfg.image_height <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_KERNEL_SIZE:  prdata = {28'd0, cfg.kernel_size};
      REG_IMAGE_WIDTH:  prdata = {20'd0, cfg.image_width};
      REG_IMAGE_HEIGHT: prdata = {20'd0, cfg.image_height};
      default:          prdata = 32'd0;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/core/bbf_line_store.sv =====
// Line store: last rows of pixels, one write and one read port
`default_nettype none
module bbf_line_store (
  input  logic                            clk,
  input  logic                            we,
  input  logic [bbf_pkg::LS_ADDR_W-1:0]   waddr,
  input  logic [31:0]                     wdata,
  input  logic                            re,
  input  logic [bbf_pkg::LS_ADDR_W-1:0]   raddr,
  output logic [31:0]                     rdata
);
  import bbf_pkg::*;

  logic [31:0] mem [0:LS_DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/bbf_col_store.sv =====
// Column sum store: per column, three channel sums; one write, two reads
`default_nettype none
module bbf_col_store (
  input  logic                         clk,
  input  logic                         we,
  input  logic [bbf_pkg::COL_W-1:0]    waddr,
  input  bbf_pkg::bbf_col_t            wdata,
  input  logic                         re,
  input  logic [bbf_pkg::COL_W-1:0]    raddr0,
  input  logic [bbf_pkg::COL_W-1:0]    raddr1,
  output bbf_pkg::bbf_col_t            rdata0,
  output bbf_pkg::bbf_col_t            rdata1
);
  import bbf_pkg::*;

  bbf_col_t mem [0:MAX_WIDTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/argb_box_blur_filter.sv =====
// Top level of the ARGB box blur filter
//
//  port     | dir | payload                       | handshake
//  pix_in   | in  | pixel_in[31:0], drain         | valid/ready
//  pix_out  | out | pixel_out[31:0], end_of_frame | valid/ready
//  apb      | in  | kernel_size, width, height    | psel/penable, pready=1
//
// Each item steps through accept, read and update, and divide too when it yields a
// result; a drain inside the frame stops after accept and read. The read-modify-write
// of the line store and column sum store sets these steps; no new item is taken until
// the last one is through. Output register frees the input while a result waits.
// Reset needs no clearing pass: column sums read as zero on the first row of a frame.
// A stalled output holds the divide step until the output register frees.
`default_nettype none
module argb_box_blur_filter (
  input  logic                          clk,
  input  logic                          rst,
  bbf_pix_in_if.sink                    pix_in,
  bbf_pix_out_if.source                 pix_out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bbf_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import bbf_pkg::*;

  bbf_cfg_t   cfg;
  bbf_state_t state, state_next;

  // frame settings latched on the first item
  logic [3:0]          cur_k;
  logic [2:0]          cur_hk;
  logic [11:0]         cur_w, cur_h;
  logic [FS_W-1:0]     total, fs;
  logic [DLY_W-1:0]    delay;
  logic [RECIP_W-1:0]  recip;

  logic [3:0]          k_eff;
  logic [11:0]         w_eff, h_eff;
  logic [FS_W-1:0]     total_eff;
  logic [DLY_W-1:0]    delay_eff;

  logic [31:0]         in_pix;
  logic                in_drain;
  logic [COL_W-1:0]    in_c, out_c;
  logic [ROW_W-1:0]    in_r, out_r;
  logic [SLOT_W-1:0]   wr_row, out_row, old_row;
  logic [SLOT_W:0]     old_diff;

  logic                do_upd, do_out, interior, eof;
  logic [LS_ADDR_W-1:0] wr_addr, ob_addr;
  logic [COL_W-1:0]    col_idx;
  logic                first_row, r_ge_k, c_zero, c_ge_k;

  logic [2:0][WS_W-1:0] win, win_new;
  bbf_col_t            col_new, cs_rd0, cs_rd1;
  logic [31:0]         ls_rd;
  logic [40:0]         prod [3];
  logic [23:0]         quot;

  logic                accept, in_frame, skip, emit, last_col, out_last_col, eof_now;
  logic                out_valid, out_free;
  logic [31:0]         out_pixel;
  logic                out_eof;

  bbf_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  bbf_line_store u_ls (
    .clk,
    .we    (state == ST_UPDATE && do_upd),
    .waddr (wr_addr),
    .wdata (in_pix),
    .re    (state == ST_READ || state == ST_UPDATE),
    .raddr ((state == ST_READ) ? {old_row, in_c} : ob_addr),
    .rdata (ls_rd)
  );

  bbf_col_store u_cs (
    .clk,
    .we     (state == ST_UPDATE && do_upd),
    .waddr  (col_idx),
    .wdata  (col_new),
    .re     (state == ST_READ),
    .raddr0 (in_c),
    .raddr1 (in_c - COL_W'(cur_k)),
    .rdata0 (cs_rd0),
    .rdata1 (cs_rd1)
  );

  // frame settings as they would be latched now
  always_comb begin
    if (cfg.kernel_size == 4'd0)   k_eff = 4'd1;
    else if (cfg.kernel_size[0])   k_eff = cfg.kernel_size;
    else                           k_eff = cfg.kernel_size - 4'd1;
    if (cfg.image_width == 12'd0)        w_eff = 12'd1;
    else if (cfg.image_width > MAX_W_VAL) w_eff = MAX_W_VAL;
    else                                  w_eff = cfg.image_width;
    h_eff     = (cfg.image_height == 12'd0) ? 12'd1 : cfg.image_height;
    total_eff = {12'd0, w_eff} * {12'd0, h_eff};
    delay_eff = ({12'd0, k_eff[3:1]} * {3'd0, w_eff}) + {12'd0, k_eff[3:1]};
  end

  assign accept       = pix_in.valid && pix_in.ready;
  assign pix_in.ready = (state == ST_IDLE);
  assign in_frame     = fs < total;
  assign skip         = in_frame && in_drain;
  assign emit         = fs >= FS_W'(delay);
  assign last_col     = ({1'b0, in_c} == cur_w - 12'd1);
  assign out_last_col = ({1'b0, out_c} == cur_w - 12'd1);
  assign eof_now      = out_last_col && (out_r == cur_h - 12'd1);
  assign out_free     = !out_valid || pix_out.ready;

  // slot of the row that leaves the column sums, (r - K) mod 15
  always_comb begin
    old_diff = {1'b0, wr_row} - {1'b0, cur_k};
    if (old_diff[SLOT_W]) old_diff = old_diff + (SLOT_W+1)'(MAX_KERNEL);
    old_row = old_diff[SLOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) state_next = ST_READ;
      ST_READ:   state_next = skip ? ST_IDLE : ST_UPDATE;
      ST_UPDATE: state_next = do_out ? ST_DIVIDE : ST_IDLE;
      ST_DIVIDE: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // running sums for the current pixel
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [CS_W-1:0] base, addv, subv;
      logic [WS_W-1:0] wbase, wsub;
      base  = first_row ? '0 : cs_rd0[i];
      addv  = CS_W'(in_pix[16-8*i +: 8]);
      subv  = r_ge_k ? CS_W'(ls_rd[16-8*i +: 8]) : '0;
      col_new[i] = base + addv - subv;
      wbase = c_zero ? '0 : win[i];
      wsub  = c_ge_k ? WS_W'(cs_rd1[i]) : '0;
      win_new[i] = wbase + WS_W'(col_new[i]) - wsub;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i] = {25'd0, win[i]} * {16'd0, recip};
      quot[16-8*i +: 8] = prod[i][RECIP_SH +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fs      <= '0;
      cur_k   <= 4'd1;
      cur_hk  <= 3'd0;
      cur_w   <= 12'd1;
      cur_h   <= 12'd1;
      total   <= FS_W'(1);
      delay   <= '0;
      recip   <= bbf_recip(4'd1);
      in_c    <= '0;
      in_r    <= '0;
      wr_row  <= '0;
      out_c   <= '0;
      out_r   <= '0;
      out_row <= '0;
      do_upd  <= 1'b0;
      do_out  <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            in_pix   <= pix_in.pixel_in;
            in_drain <= pix_in.drain;
            if (fs == '0) begin
              cur_k   <= k_eff;
              cur_hk  <= k_eff[3:1];
              cur_w   <= w_eff;
              cur_h   <= h_eff;
              total   <= total_eff;
              delay   <= delay_eff;
              recip   <= bbf_recip(k_eff);
              in_c    <= '0;
              in_r    <= '0;
              wr_row  <= '0;
              out_c   <= '0;
              out_r   <= '0;
              out_row <= '0;
            end
          end
        end
        ST_READ: begin
          if (!skip) begin
            do_upd    <= in_frame;
            do_out    <= emit;
            wr_addr   <= {wr_row, in_c};
            col_idx   <= in_c;
            first_row <= (in_r == '0);
            r_ge_k    <= (in_r >= {8'd0, cur_k});
            c_zero    <= (in_c == '0);
            c_ge_k    <= (in_c >= {7'd0, cur_k});
            if (in_frame) begin
              in_c <= last_col ? '0 : in_c + COL_W'(1);
              if (last_col) begin
                in_r   <= in_r + ROW_W'(1);
                wr_row <= (wr_row == LAST_SLOT) ? '0 : wr_row + SLOT_W'(1);
              end
            end
            if (emit) begin
              interior <= (out_r >= {9'd0, cur_hk})
                       && ({1'b0, out_r} + 13'(cur_hk) < {1'b0, cur_h})
                       && ({1'b0, out_c} >= 12'(cur_hk))
                       && ({1'b0, out_c} + 12'(cur_hk) < cur_w);
              eof     <= eof_now;
              ob_addr <= {out_row, out_c};
              out_c   <= out_last_col ? '0 : out_c + COL_W'(1);
              if (out_last_col) begin
                out_r   <= out_r + ROW_W'(1);
                out_row <= (out_row == LAST_SLOT) ? '0 : out_row + SLOT_W'(1);
              end
            end
            fs <= (emit && eof_now) ? '0 : fs + FS_W'(1);
          end
        end
        ST_UPDATE: begin
          if (do_upd) win <= win_new;
        end
        ST_DIVIDE: ;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DIVIDE && out_free) begin
      out_valid <= 1'b1;
    end else if (pix_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DIVIDE && out_free) begin
      out_pixel <= interior ? {ALPHA_FULL, quot} : ls_rd;
      out_eof   <= eof;
    end
  end

  assign pix_out.valid        = out_valid;
  assign pix_out.pixel_out    = out_pixel;
  assign pix_out.end_of_frame = out_eof;
endmodule
`default_nettype wire

// ===== rtl/core/bbf_checker.sv =====
// Port-level checks of the box blur filter, bound to the top level
`default_nettype none
`include "argb_box_blur_filter_assert.svh"
module bbf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_pixel,
  input logic        out_eof
);
  `BBF_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `BBF_ASSERT_NXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(out_pixel) && $stable(out_eof))
  // one item in flight: input closes right after an accept
  `BBF_ASSERT_NXT(a_one_item, clk, rst, in_valid && in_ready, !in_ready)
  `BBF_ASSERT_IMP(a_reset_quiet, clk, rst, $past(rst), !out_valid)
endmodule

bind argb_box_blur_filter bbf_checker u_bbf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pix_in.valid),
  .in_ready  (pix_in.ready),
  .out_valid (pix_out.valid),
  .out_ready (pix_out.ready),
  .out_pixel (pix_out.pixel_out),
  .out_eof   (pix_out.end_of_frame)
);
`default_nettype wire

// ===== verif/argb_box_blur_filter_checker.sv =====
// Checker: predicts blurred pixels from the watched streams and compares results
module argb_box_blur_filter_checker (
  input  logic                        clk,
  input  logic                        rst,
  bbf_pix_in_if                       pin,
  bbf_pix_out_if                      pout,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bbf_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output int                          errors,
  output int                          pending
);
  import bbf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] pixel;
    logic        eof;
  } blur_result_t;

  logic [3:0]  kernel_reg;
  logic [11:0] width_reg;
  logic [11:0] height_reg;

  logic [31:0] rows [LS_DEPTH];
  int unsigned col_sum [MAX_WIDTH][3];
  int unsigned win_sum [3];
  int unsigned col_pos, row_pos, step, k_cur, w_cur, h_cur;

  blur_result_t blur_q[$];

  function automatic int unsigned chan(logic [31:0] p, int ch);
    return (p >> (16 - 8 * ch)) & 32'hFF;
  endfunction

  task automatic start_frame();
    k_cur = (kernel_reg == 0) ? 1 : kernel_reg;
    if (k_cur % 2 == 0) k_cur--;
    if (k_cur > MAX_KERNEL) k_cur = (MAX_KERNEL % 2) ? MAX_KERNEL : MAX_KERNEL - 1;
    w_cur = (width_reg == 0) ? 1 : width_reg;
    if (w_cur > MAX_WIDTH) w_cur = MAX_WIDTH;
    h_cur = (height_reg == 0) ? 1 : height_reg;
    foreach (col_sum[i, j]) col_sum[i][j] = 0;
    foreach (win_sum[j]) win_sum[j] = 0;
    col_pos = 0;
    row_pos = 0;
  endtask

  task automatic take_pixel(logic [31:0] pix);
    logic [31:0] oldp;
    oldp = 0;
    if (row_pos >= k_cur)
      oldp = rows[((row_pos - k_cur) % MAX_KERNEL) * MAX_WIDTH + col_pos];
    rows[(row_pos % MAX_KERNEL) * MAX_WIDTH + col_pos] = pix;
    if (col_pos == 0) foreach (win_sum[j]) win_sum[j] = 0;
    for (int ch = 0; ch < 3; ch++) begin
      col_sum[col_pos][ch] = col_sum[col_pos][ch] + chan(pix, ch) - chan(oldp, ch);
      win_sum[ch] += col_sum[col_pos][ch];
      if (col_pos >= k_cur) win_sum[ch] -= col_sum[col_pos - k_cur][ch];
    end
    col_pos++;
    if (col_pos >= w_cur) begin
      col_pos = 0;
      row_pos++;
    end
  endtask

  task automatic predict_blur(logic [31:0] pix, logic drn);
    int unsigned total, half, lag, oi, ro, co, n;
    blur_result_t r;
    if (step == 0) start_frame();
    total = w_cur * h_cur;
    half = k_cur / 2;
    lag = half * w_cur + half;
    if (step < total) begin
      if (drn) return;
      take_pixel(pix);
    end
    if (step < lag) begin
      step++;
      return;
    end
    oi = step - lag;
    ro = oi / w_cur;
    co = oi % w_cur;
    if (ro >= half && ro + half < h_cur && co >= half && co + half < w_cur) begin
      n = k_cur * k_cur;
      r.pixel = {ALPHA_FULL, 8'(win_sum[0] / n), 8'(win_sum[1] / n), 8'(win_sum[2] / n)};
    end else begin
      r.pixel = rows[(ro % MAX_KERNEL) * MAX_WIDTH + co];
    end
    r.eof = (oi == total - 1);
    step = r.eof ? 0 : step + 1;
    blur_q.push_back(r);
  endtask

  always @(posedge clk) begin
    blur_result_t want;
    if (rst) begin
      kernel_reg <= KERNEL_RST;
      width_reg  <= WIDTH_RST;
      height_reg <= HEIGHT_RST;
      step = 0;
      k_cur = 1;
      w_cur = 1;
      h_cur = 1;
      blur_q.delete();
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[3:2])
          REG_KERNEL_SIZE:  kernel_reg <= pwdata[3:0];
          REG_IMAGE_WIDTH:  width_reg  <= pwdata[11:0];
          REG_IMAGE_HEIGHT: height_reg <= pwdata[11:0];
          default: ;
        endcase
      end
      if (pout.valid && pout.ready) begin
        if (blur_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h eof %b", pout.pixel_out,
                                     pout.end_of_frame);
        end else begin
          want = blur_q.pop_front();
          if (want.pixel !== pout.pixel_out || want.eof !== pout.end_of_frame) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected %h eof %b, got %h eof %b", want.pixel,
                       want.eof, pout.pixel_out, pout.end_of_frame);
          end
        end
      end
      if (pin.valid && pin.ready) predict_blur(pin.pixel_in, pin.drain);
    end
    pending = blur_q.size();
  end

  initial begin
    errors = 0;
    pending = 0;
  end
endmodule

// ===== verif/tb.sv =====
// Testbench top: clock, reset, frame stimulus, register writes and verdict
module tb;
  import bbf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int errors, pending;
  int items_sent = 0;
  int idle_cycles = 0;
  bit quiet = 0;

  bbf_pix_in_if  pin ();
  bbf_pix_out_if pout ();

  argb_box_blur_filter dut (
    .clk, .rst, .pix_in(pin), .pix_out(pout),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  argb_box_blur_filter_checker chk (
    .clk, .rst, .pin, .pout,
    .psel, .penable, .pwrite, .paddr, .pwdata, .errors, .pending
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // watchdog: cycles with no handshake of any kind
  always @(posedge clk) begin
    if ((pin.valid && pin.ready) || (pout.valid && pout.ready) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("argb_box_blur_filter test failed");
      $finish;
    end
  end

  // result side stalls
  initial begin
    int n;
    pout.ready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      n = quiet ? 0 : $urandom_range(0, 16);
      if (n > 0) begin
        pout.ready = 0;
        repeat (n) @(negedge clk);
      end
      pout.ready = 1;
      do @(posedge clk); while (!(pout.valid && pout.ready));
      @(negedge clk);
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel = 1; penable = 0; pwrite = 1; paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  task automatic send_item(logic [31:0] pix, logic drn);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    if (gap > 0) begin
      pin.valid = 0;
      repeat (gap) @(negedge clk);
    end
    pin.valid = 1;
    pin.pixel_in = pix;
    pin.drain = drn;
    do @(posedge clk); while (!pin.ready);
    items_sent++;
  endtask

  function automatic logic [31:0] rand_pixel();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // one frame; the register values are clamped as the block does
  task automatic run_frame(logic [3:0] ks, logic [11:0] w, logic [11:0] h);
    int k, we, he, total, lag;
    k = (ks == 0) ? 1 : ks;
    if (k % 2 == 0) k--;
    we = (w == 0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
    he = (h == 0) ? 1 : h;
    total = we * he;
    lag = (k / 2) * we + k / 2;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    reg_write(REG_KERNEL_SIZE, 32'(ks));
    reg_write(REG_IMAGE_WIDTH, 32'(w));
    reg_write(REG_IMAGE_HEIGHT, 32'(h));
    quiet = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < total; i++) begin
      // drain inside the frame is ignored, but never as the first item
      if (i > 0 && $urandom_range(0, 9) == 0) send_item($urandom(), 1'b1);
      send_item(rand_pixel(), 1'b0);
    end
    // tail: pixels here count as drains
    for (int i = 0; i < lag; i++) send_item($urandom(), 1'($urandom_range(0, 1)));
    @(negedge clk);
    pin.valid = 0;
  endtask

  initial begin
    pin.valid = 0;
    pin.pixel_in = '0;
    pin.drain = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    run_frame(4'd0, 12'd3, 12'd3);
    run_frame(4'd2, 12'd4, 12'd4);
    run_frame(4'd3, 12'd0, 12'd0);
    run_frame(4'd14, 12'd16, 12'd15);
    run_frame(4'd15, 12'd15, 12'd16);
    // tail longer than the frame
    run_frame(4'd7, 12'd20, 12'd2);
    run_frame(4'd5, 12'd1, 12'd40);
    while (items_sent < 950)
      run_frame(4'($urandom_range(0, 15)), 12'($urandom_range(1, 14)),
                12'($urandom_range(1, 12)));

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("argb_box_blur_filter test passed");
    else
      $display("argb_box_blur_filter test failed");
    $finish;
  end
endmodule

// ===== argb_box_blur_filter.f =====
+incdir+rtl/core
rtl/core/bbf_pkg.sv
rtl/core/bbf_stream_if.sv
rtl/core/bbf_cfg.sv
rtl/core/bbf_line_store.sv
rtl/core/bbf_col_store.sv
rtl/core/argb_box_blur_filter.sv
rtl/core/bbf_checker.sv
verif/argb_box_blur_filter_checker.sv
verif/tb.sv
